### hw/rtl/accel_six_face_calibration_assert.svh
// assertion macros for the six face calibration block
`ifndef ACCEL_SIX_FACE_CALIBRATION_ASSERT_SVH
`define ACCEL_SIX_FACE_CALIBRATION_ASSERT_SVH

`ifndef ASSERT_OFF
`define ACAL_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("acal assertion failed");
`define ACAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acal assertion failed");
`else
`define ACAL_ASSERT_ALWAYS(label, clk, rst, expr)
`define ACAL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/acal_pkg.sv
// types, codes and constants shared by the six face calibration block
package acal_pkg;

  localparam int unsigned FACES_NEEDED_DEF = 6;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPAN_LOW  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPAN_HIGH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLES   = 2'd2;

  localparam logic [15:0] SPAN_LOW_RESET  = 16'd20000;
  localparam logic [15:0] SPAN_HIGH_RESET = 16'd40000;
  localparam logic [7:0]  SAMPLES_RESET   = 8'd50;

  localparam logic signed [15:0] AXIS_MAX = 16'sh7fff;
  localparam logic signed [15:0] AXIS_MIN = 16'sh8000;

  localparam logic [2:0] SIDE_FIRST = 3'd1;
  localparam logic [2:0] SIDE_LAST  = 3'd6;

  typedef logic signed [15:0] sample_t;

  typedef enum logic [2:0] {
    ST_TAKEN     = 3'd0,
    ST_FACE_DONE = 3'd1,
    ST_CAL_DONE  = 3'd2,
    ST_BAD_SIDE  = 3'd3,
    ST_READ_ERR  = 3'd4,
    ST_RESTART   = 3'd5
  } status_t;

  typedef struct packed {
    logic       req_type;
    logic [2:0] side;
    logic       read_error;
    sample_t    accel_x;
    sample_t    accel_y;
    sample_t    accel_z;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] faces_done;
    sample_t    offset_x;
    sample_t    offset_y;
    sample_t    offset_z;
    logic [2:0] span_warning;
    sample_t    low_x;
    sample_t    low_y;
    sample_t    low_z;
    sample_t    high_x;
    sample_t    high_y;
    sample_t    high_z;
  } out_item_t;

  // record handed from the tracking stage to the report stage
  typedef struct packed {
    status_t         status;
    logic [2:0]      faces_done;
    sample_t [2:0]   low;
    sample_t [2:0]   high;
  } track_rec_t;

endpackage

### hw/rtl/acal_if.sv
// valid/ready channels for samples and results
interface acal_in_if;
  logic               valid;
  logic               ready;
  acal_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acal_out_if;
  logic                valid;
  logic                ready;
  acal_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/acal_track.sv
// face and round extreme tracking, counters and status decision
`include "accel_six_face_calibration_assert.svh"

module acal_track #(
  parameter int unsigned FACES_NEEDED = acal_pkg::FACES_NEEDED_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           samples_per_face,
  input  logic                 in_valid,
  input  acal_pkg::in_item_t   in_item,
  output logic                 in_ready,
  input  logic                 rec_ready,
  output logic                 rec_valid,
  output acal_pkg::track_rec_t rec
);
  import acal_pkg::*;

  sample_t [2:0] face_min;
  sample_t [2:0] face_max;
  sample_t [2:0] round_min;
  sample_t [2:0] round_max;
  logic [7:0]    sample_count;
  logic [2:0]    face_count;

  sample_t [2:0] face_min_next;
  sample_t [2:0] face_max_next;
  sample_t [2:0] round_min_next;
  sample_t [2:0] round_max_next;
  logic [7:0]    sample_count_next;
  logic [2:0]    face_count_next;
  track_rec_t    rec_next;

  sample_t [2:0] samp;
  sample_t [2:0] fmin_upd;
  sample_t [2:0] fmax_upd;
  sample_t [2:0] rmin_merge;
  sample_t [2:0] rmax_merge;
  logic [7:0]    count_inc;
  logic [2:0]    faces_inc;
  logic          side_ok;
  logic          face_end;
  logic          round_end;
  logic          fire;

  assign fire     = in_valid && in_ready;
  assign in_ready = !rec_valid || rec_ready;

  assign samp[0] = in_item.accel_x;
  assign samp[1] = in_item.accel_y;
  assign samp[2] = in_item.accel_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      fmin_upd[a]   = (samp[a] < face_min[a]) ? samp[a] : face_min[a];
      fmax_upd[a]   = (samp[a] > face_max[a]) ? samp[a] : face_max[a];
      rmin_merge[a] = (fmin_upd[a] < round_min[a]) ? fmin_upd[a] : round_min[a];
      rmax_merge[a] = (fmax_upd[a] > round_max[a]) ? fmax_upd[a] : round_max[a];
    end
  end

  assign side_ok   = (in_item.side >= SIDE_FIRST) && (in_item.side <= SIDE_LAST);
  assign count_inc = sample_count + 8'd1;
  assign face_end  = (count_inc == 8'd0) || (count_inc >= samples_per_face);
  assign faces_inc = face_count + 3'd1;
  assign round_end = faces_inc >= 3'(FACES_NEEDED);

  always_comb begin
    face_min_next     = face_min;
    face_max_next     = face_max;
    round_min_next    = round_min;
    round_max_next    = round_max;
    sample_count_next = sample_count;
    face_count_next   = face_count;
    rec_next.status     = ST_TAKEN;
    rec_next.faces_done = face_count;
    rec_next.low        = rmin_merge;
    rec_next.high       = rmax_merge;
    priority if (in_item.req_type) begin
      face_min_next     = {3{AXIS_MAX}};
      face_max_next     = {3{AXIS_MIN}};
      round_min_next    = {3{AXIS_MAX}};
      round_max_next    = {3{AXIS_MIN}};
      sample_count_next = 8'd0;
      face_count_next   = 3'd0;
      rec_next.status     = ST_RESTART;
      rec_next.faces_done = 3'd0;
    end else if (sample_count == 8'd0 && !side_ok) begin
      rec_next.status = ST_BAD_SIDE;
    end else if (in_item.read_error) begin
      face_min_next     = {3{AXIS_MAX}};
      face_max_next     = {3{AXIS_MIN}};
      sample_count_next = 8'd0;
      rec_next.status   = ST_READ_ERR;
    end else if (!face_end) begin
      face_min_next     = fmin_upd;
      face_max_next     = fmax_upd;
      sample_count_next = count_inc;
    end else begin
      face_min_next     = {3{AXIS_MAX}};
      face_max_next     = {3{AXIS_MIN}};
      round_min_next    = rmin_merge;
      round_max_next    = rmax_merge;
      sample_count_next = 8'd0;
      rec_next.faces_done = faces_inc;
      if (round_end) begin
        face_count_next = 3'd0;
        rec_next.status = ST_CAL_DONE;
      end else begin
        face_count_next = faces_inc;
        rec_next.status = ST_FACE_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_min     <= {3{AXIS_MAX}};
      face_max     <= {3{AXIS_MIN}};
      round_min    <= {3{AXIS_MAX}};
      round_max    <= {3{AXIS_MIN}};
      sample_count <= 8'd0;
      face_count   <= 3'd0;
      rec_valid    <= 1'b0;
    end else if (fire) begin
      face_min     <= face_min_next;
      face_max     <= face_max_next;
      round_min    <= round_min_next;
      round_max    <= round_max_next;
      sample_count <= sample_count_next;
      face_count   <= face_count_next;
      rec_valid    <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rec <= rec_next;
    end
  end

  `ACAL_ASSERT_ALWAYS(a_face_count_range, clk, rst, face_count < 3'(FACES_NEEDED))
  `ACAL_ASSERT_NEXT(a_restart_clears, clk, rst, fire && in_item.req_type, sample_count == 8'd0 && face_count == 3'd0 && rec.status == ST_RESTART)
  `ACAL_ASSERT_ALWAYS(a_face_order, clk, rst, sample_count == 8'd0 || (face_min[0] <= face_max[0] && face_min[1] <= face_max[1] && face_min[2] <= face_max[2]))
  `ACAL_ASSERT_NEXT(a_cal_done_count, clk, rst, fire && rec_next.status == ST_CAL_DONE, face_count == 3'd0 && rec.faces_done == 3'(FACES_NEEDED))

endmodule

### hw/rtl/acal_report.sv
// offset and span check on round completion, result register
module acal_report (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          span_low_limit,
  input  logic [15:0]          span_high_limit,
  input  logic                 rec_valid,
  input  acal_pkg::track_rec_t rec,
  output logic                 rec_ready,
  acal_out_if.source           result
);
  import acal_pkg::*;

  logic signed [16:0] sum [3];
  logic signed [16:0] half [3];
  logic signed [16:0] span [3];
  sample_t [2:0]      offset;
  logic [2:0]         warn;
  logic               done;
  out_item_t          item_next;
  logic signed [16:0] lim_lo;
  logic signed [16:0] lim_hi;

  assign rec_ready = !result.valid || result.ready;
  assign done      = rec.status == ST_CAL_DONE;
  assign lim_lo    = $signed({1'b0, span_low_limit});
  assign lim_hi    = $signed({1'b0, span_high_limit});

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a]    = $signed({rec.high[a][15], rec.high[a]}) + $signed({rec.low[a][15], rec.low[a]});
      // round toward zero
      half[a]   = (sum[a] + $signed({16'd0, sum[a][16]})) >>> 1;
      offset[a] = half[a][15:0];
      span[a]   = $signed({rec.high[a][15], rec.high[a]}) - $signed({rec.low[a][15], rec.low[a]});
      warn[a]   = (span[a] < lim_lo) || (span[a] > lim_hi);
    end
  end

  always_comb begin
    item_next              = '0;
    item_next.status       = rec.status;
    item_next.faces_done   = rec.faces_done;
    if (done) begin
      item_next.offset_x     = offset[0];
      item_next.offset_y     = offset[1];
      item_next.offset_z     = offset[2];
      item_next.span_warning = warn;
      item_next.low_x        = rec.low[0];
      item_next.low_y        = rec.low[1];
      item_next.low_z        = rec.low[2];
      item_next.high_x       = rec.high[0];
      item_next.high_y       = rec.high[1];
      item_next.high_z       = rec.high[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (rec_valid && rec_ready) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      result.data <= item_next;
    end
  end

endmodule

### hw/rtl/accel_six_face_calibration.sv
// top level of the six face accelerometer calibration block
//
//   channel   dir  payload                          transaction
//   sample    in   req_type side read_error xyz     valid && ready
//   result    out  status counts offsets extremes   valid && ready
//   cfg       in   cfg_addr cfg_wdata               cfg_we
//
// one transaction per cycle sustained while results are taken; a sample reaches the result
// through the input register, tracking register and result register
// tracking state updates in the single cycle an item leaves the input register
// reset clears extremes, counters and limits to defaults; no clearing pass
// a stalled result holds the pipe back one stage at a time
module accel_six_face_calibration #(
  parameter int unsigned FACES_NEEDED = acal_pkg::FACES_NEEDED_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [acal_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [acal_pkg::CFG_DATA_W-1:0] cfg_wdata,
  acal_in_if.sink                       sample,
  acal_out_if.source                    result
);
  import acal_pkg::*;

  logic [15:0] span_low_limit;
  logic [15:0] span_high_limit;
  logic [7:0]  samples_per_face;

  logic        in_valid;
  in_item_t    in_item;
  logic        track_ready;
  logic        rec_valid;
  logic        rec_ready;
  track_rec_t  rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_low_limit   <= SPAN_LOW_RESET;
      span_high_limit  <= SPAN_HIGH_RESET;
      samples_per_face <= SAMPLES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SPAN_LOW:  span_low_limit   <= cfg_wdata;
        CFG_SPAN_HIGH: span_high_limit  <= cfg_wdata;
        CFG_SAMPLES:   samples_per_face <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign sample.ready = !in_valid || track_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      in_valid <= 1'b1;
    end else if (track_ready) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_item <= sample.data;
    end
  end

  acal_track #(
    .FACES_NEEDED (FACES_NEEDED)
  ) u_track (
    .clk              (clk),
    .rst              (rst),
    .samples_per_face (samples_per_face),
    .in_valid         (in_valid),
    .in_item          (in_item),
    .in_ready         (track_ready),
    .rec_ready        (rec_ready),
    .rec_valid        (rec_valid),
    .rec              (rec)
  );

  acal_report u_report (
    .clk             (clk),
    .rst             (rst),
    .span_low_limit  (span_low_limit),
    .span_high_limit (span_high_limit),
    .rec_valid       (rec_valid),
    .rec             (rec),
    .rec_ready       (rec_ready),
    .result          (result)
  );

endmodule

### bench/testbench.sv
// testbench for the six face accelerometer calibration block
module testbench;
  import acal_pkg::*;

  localparam int IDLE_PCT     = 25;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 8;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    in_item_t              item;
    bit                    typed;
    status_t               st;
    logic [2:0]            fd;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    steady;

  acal_in_if  samp_ch ();
  acal_out_if res_ch ();

  accel_six_face_calibration u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sample    (samp_ch),
    .result    (res_ch)
  );

  // calibration state mirrored by the predictor
  logic [15:0] span_lo;
  logic [15:0] span_hi;
  logic [7:0]  face_len;
  sample_t     rnd_min [3];
  sample_t     rnd_max [3];
  sample_t     face_min [3];
  sample_t     face_max [3];
  logic [7:0]  face_samples;
  logic [2:0]  faces;

  out_item_t awaited_reports[$];
  int        mismatches;
  int        accepted;
  int        reports;
  int        seen [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void clear_face();
    for (int a = 0; a < 3; a++) begin
      face_min[a] = AXIS_MAX;
      face_max[a] = AXIS_MIN;
    end
    face_samples = '0;
  endfunction

  function automatic void clear_round();
    for (int a = 0; a < 3; a++) begin
      rnd_min[a] = AXIS_MAX;
      rnd_max[a] = AXIS_MIN;
    end
    clear_face();
    faces = '0;
  endfunction

  function automatic out_item_t calibrate_step(in_item_t it);
    out_item_t  r;
    sample_t    s [3];
    sample_t    off [3];
    logic [2:0] warn;
    int         span;
    r = '0;
    warn = '0;
    s[0] = it.accel_x;
    s[1] = it.accel_y;
    s[2] = it.accel_z;
    if (it.req_type) begin
      clear_round();
      r.status = ST_RESTART;
    end else if (face_samples == 0 && (it.side < SIDE_FIRST || it.side > SIDE_LAST)) begin
      r.status = ST_BAD_SIDE;
    end else if (it.read_error) begin
      clear_face();
      r.status = ST_READ_ERR;
    end else begin
      for (int a = 0; a < 3; a++) begin
        if (s[a] < face_min[a]) face_min[a] = s[a];
        if (s[a] > face_max[a]) face_max[a] = s[a];
      end
      face_samples = face_samples + 8'd1;
      r.status = ST_TAKEN;
      if (face_samples == 0 || face_samples >= face_len) begin
        for (int a = 0; a < 3; a++) begin
          if (face_min[a] < rnd_min[a]) rnd_min[a] = face_min[a];
          if (face_max[a] > rnd_max[a]) rnd_max[a] = face_max[a];
        end
        clear_face();
        faces = faces + 3'd1;
        r.status = ST_FACE_DONE;
        if (faces >= FACES_NEEDED_DEF) begin
          // span at full width, offset truncated toward zero
          for (int a = 0; a < 3; a++) begin
            off[a] = sample_t'((int'(rnd_max[a]) + int'(rnd_min[a])) / 2);
            span = int'(rnd_max[a]) - int'(rnd_min[a]);
            if (span < int'(span_lo) || span > int'(span_hi)) warn[a] = 1'b1;
          end
          r.status = ST_CAL_DONE;
          r.offset_x = off[0];
          r.offset_y = off[1];
          r.offset_z = off[2];
          r.span_warning = warn;
          r.low_x = rnd_min[0];
          r.low_y = rnd_min[1];
          r.low_z = rnd_min[2];
          r.high_x = rnd_max[0];
          r.high_y = rnd_max[1];
          r.high_z = rnd_max[2];
        end
      end
    end
    r.faces_done = faces;
    if (r.status == ST_CAL_DONE) faces = '0;
    return r;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       pick;
    int       mode;
    sample_t  v [3];
    pick = $urandom_range(99);
    mode = $urandom_range(9);
    it.req_type = (pick < 2);
    it.read_error = (pick >= 2 && pick < 6);
    if ($urandom_range(99) < 92) it.side = 3'($urandom_range(1, 6));
    else it.side = $urandom_range(1) ? 3'd7 : 3'd0;
    for (int a = 0; a < 3; a++) begin
      if (mode < 2) v[a] = $urandom_range(1) ? AXIS_MAX : AXIS_MIN;
      else if (mode < 6) v[a] = sample_t'($urandom_range(24000) - 12000);
      else v[a] = sample_t'($urandom_range(65535));
    end
    it.accel_x = v[0];
    it.accel_y = v[1];
    it.accel_z = v[2];
    return it;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_ADDR_W-1:0] addr,
                                       logic [CFG_DATA_W-1:0] wdata);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.addr = addr;
    r.wdata = wdata;
    r.item = '0;
    r.typed = 1'b0;
    r.st = ST_TAKEN;
    r.fd = '0;
    return r;
  endfunction

  function automatic dir_row_t item_row(bit req, logic [2:0] side, bit err,
                                        int x, int y, int z,
                                        bit typed, status_t st, logic [2:0] fd);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.addr = '0;
    r.wdata = '0;
    r.item.req_type = req;
    r.item.side = side;
    r.item.read_error = err;
    r.item.accel_x = sample_t'(x);
    r.item.accel_y = sample_t'(y);
    r.item.accel_z = sample_t'(z);
    r.typed = typed;
    r.st = st;
    r.fd = fd;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send(in_item_t it, bit typed, out_item_t given);
    out_item_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      samp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samp_ch.valid <= 1'b1;
    samp_ch.data <= it;
    @(posedge clk);
    while (!samp_ch.ready) @(posedge clk);
    predicted = calibrate_step(it);
    awaited_reports.push_back(typed ? given : predicted);
    accepted++;
  endtask

  task automatic settle();
    samp_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] wdata);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      CFG_SPAN_LOW:  span_lo = wdata;
      CFG_SPAN_HIGH: span_hi = wdata;
      CFG_SAMPLES:   face_len = wdata[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      reports++;
      seen[got.status]++;
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected transaction, expected none got status %0d", $time,
                 got.status);
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("status", want.status, got.status);
        check_field("faces_done", want.faces_done, got.faces_done);
        check_field("offset_x", want.offset_x, got.offset_x);
        check_field("offset_y", want.offset_y, got.offset_y);
        check_field("offset_z", want.offset_z, got.offset_z);
        check_field("span_warning", want.span_warning, got.span_warning);
        check_field("low_x", want.low_x, got.low_x);
        check_field("low_y", want.low_y, got.low_y);
        check_field("low_z", want.low_z, got.low_z);
        check_field("high_x", want.high_x, got.high_x);
        check_field("high_y", want.high_y, got.high_y);
        check_field("high_z", want.high_z, got.high_z);
      end
    end
  end

  initial begin
    dir_row_t              plan[$];
    out_item_t             given;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [7:0]            len;
    int                    count;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    samp_ch.valid <= 1'b0;
    samp_ch.data <= '0;
    steady <= 1'b0;
    span_lo = SPAN_LOW_RESET;
    span_hi = SPAN_HIGH_RESET;
    face_len = SAMPLES_RESET;
    clear_round();

    // bad sides, restart, read error before and during a face, full round
    plan.push_back(reg_row(CFG_SAMPLES, 16'd2));
    plan.push_back(item_row(0, 3'd0, 0, 0, 0, 0, 1, ST_BAD_SIDE, 3'd0));
    plan.push_back(item_row(0, 3'd7, 0, 1, 1, 1, 1, ST_BAD_SIDE, 3'd0));
    plan.push_back(item_row(1, 3'd0, 0, 0, 0, 0, 1, ST_RESTART, 3'd0));
    plan.push_back(item_row(0, 3'd1, 1, 9, 9, 9, 1, ST_READ_ERR, 3'd0));
    plan.push_back(item_row(0, 3'd1, 0, 32767, -32768, 0, 1, ST_TAKEN, 3'd0));
    plan.push_back(item_row(0, 3'd0, 0, -32768, 32767, -1, 1, ST_FACE_DONE, 3'd1));
    plan.push_back(item_row(0, 3'd2, 0, 100, -100, 16384, 1, ST_TAKEN, 3'd1));
    plan.push_back(item_row(0, 3'd7, 1, 0, 0, 0, 1, ST_READ_ERR, 3'd1));
    plan.push_back(item_row(0, 3'd2, 0, 5, 6, 7, 1, ST_TAKEN, 3'd1));
    plan.push_back(item_row(0, 3'd0, 0, -5, -6, -7, 1, ST_FACE_DONE, 3'd2));
    plan.push_back(item_row(0, 3'd3, 0, 300, 200, 32767, 1, ST_TAKEN, 3'd2));
    plan.push_back(item_row(0, 3'd3, 0, -300, -200, -100, 1, ST_FACE_DONE, 3'd3));
    plan.push_back(item_row(0, 3'd4, 0, 1000, 1, 2, 1, ST_TAKEN, 3'd3));
    plan.push_back(item_row(0, 3'd4, 0, 2000, 3, 4, 1, ST_FACE_DONE, 3'd4));
    plan.push_back(item_row(0, 3'd5, 0, -1000, -1, -2, 1, ST_TAKEN, 3'd4));
    plan.push_back(item_row(0, 3'd5, 0, -2000, -3, -4, 1, ST_FACE_DONE, 3'd5));
    plan.push_back(item_row(0, 3'd6, 0, 7, 8, 9, 1, ST_TAKEN, 3'd5));
    plan.push_back(item_row(0, 3'd6, 0, -7, -8, -9, 0, ST_CAL_DONE, 3'd6));
    // inverted limits, then face length lowered mid-face and set to zero
    plan.push_back(reg_row(CFG_SPAN_LOW, 16'hffff));
    plan.push_back(reg_row(CFG_SPAN_HIGH, 16'd0));
    plan.push_back(reg_row(CFG_SAMPLES, 16'd3));
    plan.push_back(item_row(0, 3'd1, 0, 12, -12, 0, 1, ST_TAKEN, 3'd0));
    plan.push_back(item_row(0, 3'd1, 0, 13, -13, 1, 1, ST_TAKEN, 3'd0));
    plan.push_back(reg_row(CFG_SAMPLES, 16'd1));
    plan.push_back(item_row(0, 3'd1, 0, 14, -14, 2, 1, ST_FACE_DONE, 3'd1));
    plan.push_back(reg_row(CFG_SAMPLES, 16'd0));
    plan.push_back(item_row(0, 3'd2, 0, 20000, -20000, 3, 1, ST_FACE_DONE, 3'd2));
    plan.push_back(item_row(0, 3'd3, 0, -20000, 20000, 4, 1, ST_FACE_DONE, 3'd3));
    plan.push_back(item_row(0, 3'd4, 0, 1, 2, 3, 1, ST_FACE_DONE, 3'd4));
    plan.push_back(item_row(0, 3'd5, 0, -1, -2, -3, 1, ST_FACE_DONE, 3'd5));
    plan.push_back(item_row(0, 3'd6, 0, 32767, -32768, -32768, 0, ST_CAL_DONE, 3'd6));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].addr, plan[i].wdata);
      end else begin
        given = '0;
        given.status = plan[i].st;
        given.faces_done = plan[i].fd;
        send(plan[i].item, plan[i].typed, given);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin lo = SPAN_LOW_RESET; hi = SPAN_HIGH_RESET; len = 8'd3; end
        1: begin lo = 16'd0; hi = 16'hffff; len = 8'd1; end
        2: begin lo = 16'hffff; hi = 16'd0; len = 8'd0; end
        3: begin
          lo = 16'($urandom_range(65535));
          hi = 16'($urandom_range(65535));
          len = 8'd255;
        end
        default: begin
          lo = 16'($urandom_range(5000, 30000));
          hi = lo + 16'($urandom_range(35000));
          len = 8'($urandom_range(1, 6));
        end
      endcase
      write_reg(CFG_SPAN_LOW, lo);
      write_reg(CFG_SPAN_HIGH, hi);
      write_reg(CFG_SAMPLES, {8'd0, len});
      steady <= (p == 4);
      count = (p == 3) ? 60 : 75;
      for (int n = 0; n < count; n++) send(rand_item(), 1'b0, '0);
    end
    settle();

    $display("directed table and %0d random phases: %0d sample transactions, %0d results",
             PHASES, accepted, reports);
    $display("calibrations %0d, faces %0d, read errors %0d, bad sides %0d, restarts %0d",
             seen[ST_CAL_DONE], seen[ST_FACE_DONE], seen[ST_READ_ERR], seen[ST_BAD_SIDE],
             seen[ST_RESTART]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
